// ===== src/rtwse_pkg.sv =====
// Shared constants, command codes and types of the raw two-wire shift engine.
package rtwse_pkg;

    localparam int WORD_BITS        = 8;
    localparam int TIMER_PERIOD_DEF = 42;

    localparam int CMD_W   = 4;
    localparam int STEP_W  = 4;
    localparam int PSC_W   = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * WORD_BITS - 1);

    // Command codes carried in req_type.
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 4'd0;
    localparam logic [CMD_W-1:0] CMD_READ_BYTE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLK_HIGH   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CLK_LOW    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLK_PULSE  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DATA_HIGH  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DATA_LOW   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLK_BIT_RD = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BIT_RD     = 4'd8;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] ADDR_LSB_FIRST = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_PRESCALE  = 3'd4;

    // Decoded control for the current step of a command.
    typedef struct packed {
        logic is_edge;
        logic level;
        logic is_last;
    } step_ctl_t;

endpackage

// ===== src/rtwse_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface rtwse_req_if;
    import rtwse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     req_type;
    logic [WORD_BITS-1:0] tx_byte;
    logic [WORD_BITS-1:0] line_bits;

    modport source (output valid, req_type, tx_byte, line_bits, input ready);
    modport sink   (input valid, req_type, tx_byte, line_bits, output ready);
endinterface

interface rtwse_rsp_if;
    import rtwse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 clk_level;
    logic                 data_level;
    logic                 data_drive;
    logic [WORD_BITS-1:0] read_value;
    logic                 read_valid;
    logic                 last;

    modport source (output valid, clk_level, data_level, data_drive, read_value,
                    read_valid, last, input ready);
    modport sink   (input valid, clk_level, data_level, data_drive, read_value,
                    read_valid, last, output ready);
endinterface

// ===== src/raw_two_wire_shift_engine_unit.sv =====
// Top level of the raw two-wire shift engine: command sequencer, edge timer and APB registers.
//
// This block drives a raw two-wire link, one clock line and one bidirectional data
// line, from a stream of commands (write byte, read byte, clock high, clock low,
// clock pulse, data high, data low, clocked bit read, plain bit read). Every change
// of the clock line produces one result beat that reports the pin levels after that
// edge; data line sets and plain bit reads produce one beat each; a read byte
// reports the assembled byte with read_valid only on its sixteenth, last beat.
// Bytes go out and come in one bit per bit slot through 8-bit shift registers,
// most significant bit first unless lsb_first is set. Each clock edge waits for a
// free-running timer, a TIMER_PERIOD divider feeding a counter up to prescale, that
// overflows and restarts at each edge. An edge goes out once the timer has overflowed
// and the output register is free, so the edges of byte commands, pulses, clocked bit
// reads and single clock edges are paced by the timer, while a data set or plain bit
// read never waits on it. A sink that holds off a beat delays the following edge only
// when the stall lasts past the overflow. After a long idle time the timer has
// already overflowed and the first edge of a command waits only for a free output
// register. One command is worked on at a time; the next command is taken once the
// last beat of the current one sits in the output register, even if the sink has not
// taken it yet. Req_type codes nine to fifteen are taken and dropped without any beat.
// Writing prescale restarts the timer. The APB port has lsb_first at byte address 0
// and prescale at address 4; pready is always high.
module raw_two_wire_shift_engine_unit #(
    parameter int TIMER_PERIOD = rtwse_pkg::TIMER_PERIOD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rtwse_req_if.sink                     req,
    rtwse_rsp_if.source                   rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtwse_pkg::PADDR_W-1:0] paddr,
    input  logic [rtwse_pkg::PDATA_W-1:0] pwdata,
    output logic [rtwse_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import rtwse_pkg::*;

    localparam int                DIV_W    = $clog2(TIMER_PERIOD);
    localparam logic [DIV_W-1:0]  DIV_LAST = DIV_W'(TIMER_PERIOD - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Sequencer state.
    logic                 state_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [WORD_BITS-1:0] tx_sr_reg;
    logic [WORD_BITS-1:0] line_sr_reg;
    logic [WORD_BITS-1:0] rx_sr_reg;

    // Pin state.
    logic clock_pin_reg;
    logic data_pin_reg;
    logic data_out_reg;

    // Registers written over APB.
    logic             lsb_first_reg;
    logic [PSC_W-1:0] prescale_reg;

    // Edge timer.
    logic [DIV_W-1:0] div_cnt_reg;
    logic [PSC_W-1:0] pre_cnt_reg;
    logic             ovf_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_clk_reg;
    logic                 out_data_reg;
    logic                 out_drive_reg;
    logic [WORD_BITS-1:0] out_value_reg;
    logic                 out_rvalid_reg;
    logic                 out_last_reg;

    step_ctl_t            ctl;
    logic                 in_accept;
    logic                 known_cmd;
    logic                 slot_free;
    logic                 fire;
    logic                 cfg_write;
    logic                 tx_bit;
    logic                 line_bit;
    logic                 data_pin_next;
    logic [WORD_BITS-1:0] rx_sr_next;
    logic [WORD_BITS-1:0] value_next;
    logic                 rvalid_next;

    // What the current step does, from the command and the step count.
    always_comb
    begin
        ctl = '0;
        unique case (cmd_reg) inside
            CMD_WRITE_BYTE, CMD_READ_BYTE:
            begin
                ctl.is_edge = 1'b1;
                ctl.level   = ~step_reg[0];
                ctl.is_last = (step_reg == STEP_LAST);
            end
            CMD_CLK_PULSE, CMD_CLK_BIT_RD:
            begin
                ctl.is_edge = 1'b1;
                ctl.level   = ~step_reg[0];
                ctl.is_last = step_reg[0];
            end
            CMD_CLK_HIGH:
            begin
                ctl.is_edge = 1'b1;
                ctl.level   = 1'b1;
                ctl.is_last = 1'b1;
            end
            CMD_CLK_LOW:
            begin
                ctl.is_edge = 1'b1;
                ctl.level   = 1'b0;
                ctl.is_last = 1'b1;
            end
            CMD_DATA_HIGH, CMD_DATA_LOW, CMD_BIT_RD:
            begin
                ctl.is_last = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign known_cmd = (req.req_type <= CMD_BIT_RD);
    assign req.ready = (state_reg == ST_IDLE);
    assign in_accept = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign fire      = (state_reg == ST_RUN) && slot_free && (!ctl.is_edge || ovf_reg);

    // One bit moves per bit slot: out of the transmit register, in from the line.
    assign tx_bit   = lsb_first_reg ? tx_sr_reg[0] : tx_sr_reg[WORD_BITS-1];
    assign line_bit = line_sr_reg[0];
    assign rx_sr_next = lsb_first_reg ? {line_bit, rx_sr_reg[WORD_BITS-1:1]}
                                      : {rx_sr_reg[WORD_BITS-2:0], line_bit};

    always_comb
    begin
        data_pin_next = data_pin_reg;
        value_next    = '0;
        rvalid_next   = 1'b0;
        case (cmd_reg)
            CMD_WRITE_BYTE:
            begin
                if (!step_reg[0])
                begin
                    data_pin_next = tx_bit;
                end
            end
            CMD_READ_BYTE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    value_next  = rx_sr_next;
                    rvalid_next = 1'b1;
                end
            end
            CMD_DATA_HIGH:
            begin
                data_pin_next = 1'b1;
            end
            CMD_DATA_LOW:
            begin
                data_pin_next = 1'b0;
            end
            CMD_CLK_BIT_RD:
            begin
                if (step_reg[0])
                begin
                    value_next  = {{(WORD_BITS-1){1'b0}}, line_bit};
                    rvalid_next = 1'b1;
                end
            end
            CMD_BIT_RD:
            begin
                value_next  = {{(WORD_BITS-1){1'b0}}, line_bit};
                rvalid_next = 1'b1;
            end
            default:
            begin
                data_pin_next = data_pin_reg;
            end
        endcase
    end

    // Sequencer control and pin state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            clock_pin_reg <= 1'b0;
            data_pin_reg  <= 1'b0;
            data_out_reg  <= 1'b1;
        end
        else if (in_accept)
        begin
            step_reg <= '0;
            if (known_cmd)
            begin
                state_reg <= ST_RUN;
            end
            if (req.req_type == CMD_WRITE_BYTE)
            begin
                data_out_reg <= 1'b1;
            end
            else if (req.req_type == CMD_READ_BYTE)
            begin
                data_out_reg <= 1'b0;
            end
        end
        else if (fire)
        begin
            step_reg     <= step_reg + STEP_W'(1);
            data_pin_reg <= data_pin_next;
            if (ctl.is_edge)
            begin
                clock_pin_reg <= ctl.level;
            end
            if (ctl.is_last)
            begin
                state_reg <= ST_IDLE;
            end
        end
    end

    // Command payload and shift registers; they need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= req.req_type;
            tx_sr_reg   <= req.tx_byte;
            line_sr_reg <= req.line_bits;
            rx_sr_reg   <= '0;
        end
        else if (fire && (cmd_reg == CMD_WRITE_BYTE) && !step_reg[0])
        begin
            tx_sr_reg <= lsb_first_reg ? {1'b0, tx_sr_reg[WORD_BITS-1:1]}
                                       : {tx_sr_reg[WORD_BITS-2:0], 1'b0};
        end
        else if (fire && (cmd_reg == CMD_READ_BYTE) && step_reg[0])
        begin
            rx_sr_reg   <= rx_sr_next;
            line_sr_reg <= {1'b0, line_sr_reg[WORD_BITS-1:1]};
        end
    end

    // Output register: a finished beat waits here while the next step is prepared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_clk_reg    <= ctl.is_edge ? ctl.level : clock_pin_reg;
            out_data_reg   <= data_pin_next;
            out_drive_reg  <= data_out_reg;
            out_value_reg  <= value_next;
            out_rvalid_reg <= rvalid_next;
            out_last_reg   <= ctl.is_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.clk_level  = out_clk_reg;
    assign rsp.data_level = out_data_reg;
    assign rsp.data_drive = out_drive_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.read_valid = out_rvalid_reg;
    assign rsp.last       = out_last_reg;

    // APB registers. A write lands in the access phase.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_first_reg <= 1'b0;
            prescale_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                ADDR_LSB_FIRST: lsb_first_reg <= pwdata[0];
                ADDR_PRESCALE:  prescale_reg  <= pwdata[PSC_W-1:0];
                default:        lsb_first_reg <= lsb_first_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_LSB_FIRST: prdata = {{(PDATA_W-1){1'b0}}, lsb_first_reg};
            ADDR_PRESCALE:  prdata = {{(PDATA_W-PSC_W){1'b0}}, prescale_reg};
            default:        prdata = '0;
        endcase
    end

    // Edge timer: a period divider feeding the prescale counter. The overflow flag
    // stays up until an edge takes it; the edge and a prescale write restart it all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            pre_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if ((fire && ctl.is_edge) || (cfg_write && (paddr == ADDR_PRESCALE)))
        begin
            div_cnt_reg <= '0;
            pre_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (div_cnt_reg == DIV_LAST)
        begin
            div_cnt_reg <= '0;
            if (pre_cnt_reg == prescale_reg)
            begin
                pre_cnt_reg <= '0;
                ovf_reg     <= 1'b1;
            end
            else
            begin
                pre_cnt_reg <= pre_cnt_reg + PSC_W'(1);
            end
        end
        else
        begin
            div_cnt_reg <= div_cnt_reg + DIV_W'(1);
        end
    end

endmodule

// ===== src/rtwse_checker.sv =====
// Port-level checks of the raw two-wire shift engine, bound to its top level.
module rtwse_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [rtwse_pkg::CMD_W-1:0]     in_req_type,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            out_clk_level,
    input logic                            out_data_level,
    input logic                            out_data_drive,
    input logic [rtwse_pkg::WORD_BITS-1:0] out_read_value,
    input logic                            out_read_valid,
    input logic                            out_last
);
    import rtwse_pkg::*;

    // A stalled beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_clk_level) && $stable(out_data_level) &&
            $stable(out_data_drive) && $stable(out_read_value) &&
            $stable(out_read_valid) && $stable(out_last))
    else $error("result beat changed while stalled");

    // A completed read is always the final beat of its command.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_read_valid |-> out_last)
    else $error("read_valid on a beat that is not the last");

    // Beats that complete no read carry a zero read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_read_valid |-> (out_read_value == '0))
    else $error("read_value not zero without read_valid");

    // A known command keeps the engine busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_req_type <= CMD_BIT_RD) |=> !in_ready)
    else $error("command taken while a command was still running");

endmodule

bind raw_two_wire_shift_engine_unit rtwse_checker u_rtwse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .in_req_type    (req.req_type),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_clk_level  (rsp.clk_level),
    .out_data_level (rsp.data_level),
    .out_data_drive (rsp.data_drive),
    .out_read_value (rsp.read_value),
    .out_read_valid (rsp.read_valid),
    .out_last       (rsp.last)
);

// ===== tb/rtwse_beat_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the result beats of the two-wire shift engine and compares them.
module rtwse_beat_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    rtwse_req_if                          req_mon,
    rtwse_rsp_if                          rsp_mon,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [rtwse_pkg::PADDR_W-1:0] paddr,
    input  logic [rtwse_pkg::PDATA_W-1:0] pwdata,
    output int                            mismatch_cnt,
    output int                            beats_due_cnt
);
    import rtwse_pkg::*;

    typedef struct packed {
        logic                 clk_level;
        logic                 data_level;
        logic                 data_drive;
        logic [WORD_BITS-1:0] read_value;
        logic                 read_valid;
        logic                 last;
    } pin_beat_t;

    pin_beat_t beats_due[$];
    pin_beat_t want;

    // Pin state and bit order as the engine should hold them.
    logic lsb_first_q;
    logic clk_pin;
    logic dat_pin;
    logic dat_out;

    task automatic post_beat(input logic [WORD_BITS-1:0] rv, input logic rv_ok,
                             input logic fin);
        pin_beat_t b;
        b.clk_level  = clk_pin;
        b.data_level = dat_pin;
        b.data_drive = dat_out;
        b.read_value = rv;
        b.read_valid = rv_ok;
        b.last       = fin;
        beats_due.push_back(b);
    endtask

    task automatic model_command(input logic [CMD_W-1:0] op,
                                 input logic [WORD_BITS-1:0] tx,
                                 input logic [WORD_BITS-1:0] line);
        int                   pos;
        logic                 fin;
        logic [WORD_BITS-1:0] acc;
        acc = '0;
        case (op)
            CMD_WRITE_BYTE:
            begin
                dat_out = 1'b1;
                for (int i = 0; i < WORD_BITS; i++)
                begin
                    pos     = lsb_first_q ? i : WORD_BITS - 1 - i;
                    dat_pin = tx[pos];
                    clk_pin = 1'b1;
                    post_beat('0, 1'b0, 1'b0);
                    clk_pin = 1'b0;
                    post_beat('0, 1'b0, i == WORD_BITS - 1);
                end
            end
            CMD_READ_BYTE:
            begin
                dat_out = 1'b0;
                for (int i = 0; i < WORD_BITS; i++)
                begin
                    pos      = lsb_first_q ? i : WORD_BITS - 1 - i;
                    fin      = (i == WORD_BITS - 1);
                    clk_pin  = 1'b1;
                    post_beat('0, 1'b0, 1'b0);
                    clk_pin  = 1'b0;
                    acc[pos] = line[i];
                    post_beat(fin ? acc : '0, fin, fin);
                end
            end
            CMD_CLK_HIGH:
            begin
                clk_pin = 1'b1;
                post_beat('0, 1'b0, 1'b1);
            end
            CMD_CLK_LOW:
            begin
                clk_pin = 1'b0;
                post_beat('0, 1'b0, 1'b1);
            end
            CMD_CLK_PULSE:
            begin
                clk_pin = 1'b1;
                post_beat('0, 1'b0, 1'b0);
                clk_pin = 1'b0;
                post_beat('0, 1'b0, 1'b1);
            end
            CMD_DATA_HIGH:
            begin
                dat_pin = 1'b1;
                post_beat('0, 1'b0, 1'b1);
            end
            CMD_DATA_LOW:
            begin
                dat_pin = 1'b0;
                post_beat('0, 1'b0, 1'b1);
            end
            CMD_CLK_BIT_RD:
            begin
                clk_pin = 1'b1;
                post_beat('0, 1'b0, 1'b0);
                clk_pin = 1'b0;
                post_beat(WORD_BITS'(line[0]), 1'b1, 1'b1);
            end
            CMD_BIT_RD:
                post_beat(WORD_BITS'(line[0]), 1'b1, 1'b1);
            default:
                ;
        endcase
    endtask

    task automatic cmp_field(input string fname, input int unsigned exp_val,
                             input int unsigned got_val);
        if (exp_val != got_val)
        begin
            mismatch_cnt++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, fname, exp_val, got_val);
        end
    endtask

    // Results are compared before a new command is modeled, so a stray beat at
    // the same edge as a command cannot be matched against that command.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_due.delete();
            beats_due_cnt = 0;
            lsb_first_q   = 1'b0;
            clk_pin       = 1'b0;
            dat_pin       = 1'b0;
            dat_out       = 1'b1;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (beats_due.size() == 0)
                begin
                    mismatch_cnt++;
                    $display({"%0t: beat expected none, got clk %0b data %0b drive %0b",
                              " value 0x%0h valid %0b last %0b"},
                             $time, rsp_mon.clk_level, rsp_mon.data_level, rsp_mon.data_drive,
                             rsp_mon.read_value, rsp_mon.read_valid, rsp_mon.last);
                end
                else
                begin
                    want = beats_due.pop_front();
                    cmp_field("clk_level", want.clk_level, rsp_mon.clk_level);
                    cmp_field("data_level", want.data_level, rsp_mon.data_level);
                    cmp_field("data_drive", want.data_drive, rsp_mon.data_drive);
                    cmp_field("read_value", want.read_value, rsp_mon.read_value);
                    cmp_field("read_valid", want.read_valid, rsp_mon.read_valid);
                    cmp_field("last", want.last, rsp_mon.last);
                end
            end
            if (req_mon.valid && req_mon.ready)
                model_command(req_mon.req_type, req_mon.tx_byte, req_mon.line_bits);
            if (psel && penable && pwrite && pready && paddr == ADDR_LSB_FIRST)
                lsb_first_q = pwdata[0];
            beats_due_cnt = beats_due.size();
        end
    end

endmodule

// ===== tb/raw_two_wire_shift_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the two-wire shift engine testbench: clock, reset, command and register stimulus, verdict.
module raw_two_wire_shift_engine_unit_tb;
    import rtwse_pkg::*;

    // Generous ceiling: the slowest legal run (every beat on a timer edge at
    // prescale two, plus receiver stalls) stays well under it.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Quiet time after the last expected beat; covers a dropped command and
    // several edge spacings at the prescale settings used, so a stray beat
    // still shows before the verdict.
    localparam int DRAIN_CYCLES = 512;
    localparam int RAND_ITEMS   = 89;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_cnt;
    int beats_due_cnt;
    int cycle_cnt = 0;

    // Percent chance, per cycle, that the command side holds back or the
    // result side refuses a beat.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    rtwse_req_if req_ch ();
    rtwse_rsp_if rsp_ch ();

    raw_two_wire_shift_engine_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rtwse_beat_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_mon       (req_ch),
        .rsp_mon       (rsp_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatch_cnt  (mismatch_cnt),
        .beats_due_cnt (beats_due_cnt)
    );

    always #5ns clk = ~clk;

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side takes beats at random, held low through reset.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offers one command and returns at the edge where it is taken. Valid is
    // left high so that a following command can go out on the very next beat;
    // it only drops when the sender decides to idle or when stimulus pauses.
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [WORD_BITS-1:0] tx,
                            input logic [WORD_BITS-1:0] line);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.tx_byte   <= tx;
        req_ch.line_bits <= line;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops the command stream and waits until every predicted beat has been
    // taken, then lets a dropped command or the last timer wait run out. The
    // first edge lets the checker log the final command before it is polled.
    task automatic drain_engine();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (beats_due_cnt != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup, then access until pready. Ends with the strobes dropped
    // and a clock edge passed, so that writes can follow one another.
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the engine idle.
    task automatic set_mode(input logic lsb_first, input logic [PSC_W-1:0] psc);
        drain_engine();
        reg_write(ADDR_LSB_FIRST, PDATA_W'(lsb_first));
        reg_write(ADDR_PRESCALE, PDATA_W'(psc));
    endtask

    // Random commands, weighted toward whole bytes since those exercise the
    // shift path; a few out-of-range codes are mixed in as noise and do not
    // count toward the requested number.
    task automatic run_random(input int n);
        int                   done;
        int unsigned          roll;
        logic [CMD_W-1:0]     op;
        done = 0;
        while (done < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                op = CMD_WRITE_BYTE;
            else if (roll < 45)
                op = CMD_READ_BYTE;
            else if (roll < 50)
                op = CMD_W'($urandom_range(CMD_BIT_RD + 1, {CMD_W{1'b1}}));
            else
                op = CMD_W'($urandom_range(CMD_CLK_HIGH, CMD_BIT_RD));
            push_cmd(op, WORD_BITS'($urandom_range(0, 255)), WORD_BITS'($urandom_range(0, 255)));
            if (op <= CMD_BIT_RD)
                done++;
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= CMD_WRITE_BYTE;
        req_ch.tx_byte   <= '0;
        req_ch.line_bits <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings (most significant bit first, no
        // prescale). Byte extremes and alternating patterns both ways, data
        // sets while the pin is an output and while it is an input, repeated
        // clock levels, bit reads of both line levels, and the top and bottom
        // of the unknown code range.
        send_idle_pct = 8;
        recv_idle_pct = 67;
        push_cmd(CMD_WRITE_BYTE, 8'h00, 8'h00);
        push_cmd(CMD_WRITE_BYTE, 8'hFF, 8'hFF);
        push_cmd(CMD_WRITE_BYTE, 8'hA5, 8'h00);
        push_cmd(CMD_DATA_HIGH, 8'h00, 8'h00);
        push_cmd(CMD_READ_BYTE, 8'hFF, 8'h00);
        push_cmd(CMD_READ_BYTE, 8'h00, 8'hFF);
        push_cmd(CMD_DATA_HIGH, 8'h00, 8'h00);
        push_cmd(CMD_DATA_LOW, 8'hFF, 8'hFF);
        push_cmd(CMD_READ_BYTE, 8'h00, 8'h5A);
        push_cmd(CMD_CLK_HIGH, 8'h00, 8'h00);
        push_cmd(CMD_CLK_HIGH, 8'h00, 8'h00);
        push_cmd(CMD_CLK_LOW, 8'h00, 8'h00);
        push_cmd(CMD_CLK_LOW, 8'h00, 8'h00);
        push_cmd(CMD_CLK_PULSE, 8'h00, 8'h00);
        push_cmd(CMD_CLK_BIT_RD, 8'h00, 8'h01);
        push_cmd(CMD_CLK_BIT_RD, 8'h00, 8'hFE);
        push_cmd(CMD_BIT_RD, 8'h00, 8'hFF);
        push_cmd(CMD_BIT_RD, 8'hFF, 8'h00);
        push_cmd(CMD_BIT_RD + 4'd1, 8'hFF, 8'hFF);
        push_cmd({CMD_W{1'b1}}, 8'h00, 8'h00);
        push_cmd(CMD_WRITE_BYTE, 8'h3C, 8'h00);
        push_cmd(CMD_DATA_LOW, 8'h00, 8'h00);

        // Reversed bit order on asymmetric patterns, so a flipped order shows.
        set_mode(1'b1, '0);
        push_cmd(CMD_WRITE_BYTE, 8'h01, 8'h00);
        push_cmd(CMD_WRITE_BYTE, 8'h80, 8'h00);
        push_cmd(CMD_READ_BYTE, 8'h00, 8'h35);

        // Largest prescale: only commands that never wait on the timer, since a
        // clock edge here would wait for the largest timer period.
        set_mode(1'b0, {PSC_W{1'b1}});
        push_cmd(CMD_DATA_HIGH, 8'h00, 8'h00);
        push_cmd(CMD_BIT_RD, 8'h00, 8'h81);
        push_cmd(CMD_DATA_LOW, 8'h00, 8'h00);

        // Random phases: sender idles lightly while the receiver stalls hard,
        // then the reverse, then both run flat out.
        set_mode(1'b0, 16'd0);
        run_random(RAND_ITEMS);

        set_mode(1'b1, 16'd1);
        send_idle_pct = 67;
        recv_idle_pct = 8;
        run_random(RAND_ITEMS);

        set_mode(1'($urandom_range(0, 1)), 16'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RAND_ITEMS);

        drain_engine();
        if (mismatch_cnt == 0 && beats_due_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
